[rtl/mic_pkg.sv]
`default_nettype none

package mic_pkg;

  localparam int unsigned Axes = 3;

  // Raw sample, range and datapath widths
  localparam int unsigned RawW    = 16;
  localparam int unsigned MidW    = RawW + 1;
  localparam int unsigned DiffW   = RawW + 2;
  localparam int unsigned ScaleW  = 24;
  localparam int unsigned TotalW  = RawW + 2;
  localparam int unsigned FracW   = 16;
  localparam int unsigned DvdW    = TotalW + FracW;
  localparam int unsigned DvsW    = RawW + 2;
  localparam int unsigned FieldW  = 32;
  localparam int unsigned ProdW   = DiffW + ScaleW + 1;
  localparam int unsigned Prod3W  = ProdW + 1;
  localparam int unsigned QuotW   = 30;

  localparam logic [15:0]       TargetReset   = 16'd1000;
  localparam logic [ScaleW-1:0] ScaleOne      = 24'd65536;
  localparam logic [ScaleW-1:0] ScaleMax      = 24'hFFFFFF;
  localparam logic [31:0]       RecipFive     = 32'hCCCCCCCD;
  localparam int unsigned       QueueDepthDef = 2;

  localparam logic ActCal     = 1'b0;
  localparam logic ActCorrect = 1'b1;

  typedef struct packed {
    logic                       action;
    logic [Axes-1:0][RawW-1:0]  raw;
  } item_t;

  typedef struct packed {
    logic  valid;
    logic  cal;
    item_t item;
  } qhead_t;

endpackage

`default_nettype wire

[rtl/magnetometer_iron_calibration_core.sv]
// Magnetometer hard/soft-iron calibration core.
// Input channel (in_valid_i / in_stall_o): one item carries action_i and a
// raw three-axis sample. Action 0 is a calibration sample that widens the
// per-axis min/max and counts toward sample_target; action 1 only corrects.
// Output channel (out_valid_o / out_stall_i): one item per input, the
// corrected field (raw - mid) * scale * 0.15 uT in 1/256 uT plus the
// calibrated flag. Items come out in the order they went in.
// Config: cfg_we_i writes cfg_wdata_i into sample_target (reset 1000).
// Sequence: a queue of QueueDepth entries (two by default) decouples intake
// from the back end, which works on one item at a time. A plain item passes
// from queue head through the Mul, Scale and Recip states to the output
// register; a calibration item that recomputes the scales first runs the
// bit-serial dividers (one per axis, 34 steps each) in the Prep and Div states.
// Reset: extremes, count, midpoints (0), scales (1.0) and the flag clear;
// queue and output register empty.
// A stalled receiver holds the output item; the back end then waits with
// its next result, the queue fills, and in_stall_o rises.
`default_nettype none

module magnetometer_iron_calibration_core #(
  parameter int unsigned QueueDepth = mic_pkg::QueueDepthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [15:0]                 cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        action_i,
  input  wire logic [mic_pkg::RawW-1:0]    raw_x_i,
  input  wire logic [mic_pkg::RawW-1:0]    raw_y_i,
  input  wire logic [mic_pkg::RawW-1:0]    raw_z_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [mic_pkg::FieldW-1:0]       field_x_o,
  output logic [mic_pkg::FieldW-1:0]       field_y_o,
  output logic [mic_pkg::FieldW-1:0]       field_z_o,
  output logic                             calibrated_o
);

  logic [15:0]     target_q;
  mic_pkg::item_t  in_item;
  mic_pkg::qhead_t head;
  logic            pop;

  // Hold the sample target; software writes it only while the core is idle (not enforced here)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= mic_pkg::TargetReset;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  // Pack the axis ports into one item, x in lane 0
  assign in_item.action = action_i;
  assign in_item.raw[0] = raw_x_i;
  assign in_item.raw[1] = raw_y_i;
  assign in_item.raw[2] = raw_z_i;

  // Front end: accept items and classify them while the back end works
  mic_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item),
    .head_o    (head),
    .pop_i     (pop)
  );

  // Back end: update extremes, recompute scales, correct and present
  mic_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .target_i    (target_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .field_x_o   (field_x_o),
    .field_y_o   (field_y_o),
    .field_z_o   (field_z_o),
    .calibrated_o(calibrated_o)
  );

endmodule

`default_nettype wire

[rtl/mic_front.sv]
`default_nettype none

module mic_front #(
  parameter int unsigned QueueDepth = mic_pkg::QueueDepthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire mic_pkg::item_t in_item_i,
  output mic_pkg::qhead_t    head_o,
  input  wire logic          pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  mic_pkg::item_t  mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign in_stall_o = (cnt_q == FullCnt);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_q];
  assign head_o.cal   = (mem_q[rd_q].action == mic_pkg::ActCal);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/mic_div.sv]
`default_nettype none

module mic_div #(
  parameter int unsigned DvdW = mic_pkg::DvdW,
  parameter int unsigned DvsW = mic_pkg::DvsW
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DvdW-1:0] dividend_i,
  input  wire logic [DvsW-1:0] divisor_i,
  output logic                 done_o,
  output logic [DvdW-1:0]      quot_o
);

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvsW-1:0] dvs_q, rem_q, rem_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic [DvsW:0]   rem_sh, rem_sub;
  logic            fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_q, quo_q[DvdW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
    rem_d   = fits ? rem_sub[DvsW-1:0] : rem_sh[DvsW-1:0];
    quo_d   = {quo_q[DvdW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DvdW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

[rtl/mic_back.sv]
`default_nettype none

module mic_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mic_pkg::qhead_t       head_i,
  output logic                       pop_o,
  input  wire logic [15:0]           target_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [mic_pkg::FieldW-1:0] field_x_o,
  output logic [mic_pkg::FieldW-1:0] field_y_o,
  output logic [mic_pkg::FieldW-1:0] field_z_o,
  output logic                       calibrated_o
);

  localparam int unsigned Axes   = mic_pkg::Axes;
  localparam int unsigned RawW   = mic_pkg::RawW;
  localparam int unsigned MidW   = mic_pkg::MidW;
  localparam int unsigned DiffW  = mic_pkg::DiffW;
  localparam int unsigned ScaleW = mic_pkg::ScaleW;
  localparam int unsigned TotalW = mic_pkg::TotalW;
  localparam int unsigned DvdW   = mic_pkg::DvdW;
  localparam int unsigned DvsW   = mic_pkg::DvsW;
  localparam int unsigned ProdW  = mic_pkg::ProdW;
  localparam int unsigned Prod3W = mic_pkg::Prod3W;
  localparam int unsigned QuotW  = mic_pkg::QuotW;
  localparam int unsigned FieldW = mic_pkg::FieldW;

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StDiv,
    StMul,
    StScale,
    StRecip,
    StOut
  } state_e;

  state_e state_q;

  logic signed [RawW-1:0]   raw_q   [Axes];
  logic signed [RawW-1:0]   min_q   [Axes];
  logic signed [RawW-1:0]   max_q   [Axes];
  logic signed [MidW-1:0]   mid_q   [Axes];
  logic        [ScaleW-1:0] scale_q [Axes];
  logic                     zero_q  [Axes];
  logic signed [ProdW-1:0]  prod_q  [Axes];
  logic        [FieldW-1:0] sh_q    [Axes];
  logic                     neg_q   [Axes];
  logic        [QuotW-1:0]  quot_q  [Axes];
  logic        [15:0]       count_q;
  logic                     done_q;

  logic        [15:0]       count_inc;
  logic signed [RawW-1:0]   min_d   [Axes];
  logic signed [RawW-1:0]   max_d   [Axes];
  logic        [RawW-1:0]   range_d [Axes];
  logic        [TotalW-1:0] total_d;
  logic        [DvsW-1:0]   dvs_d   [Axes];
  logic signed [DiffW-1:0]  diff_d  [Axes];
  logic signed [ProdW-1:0]  prod_d  [Axes];
  logic signed [Prod3W-1:0] p3_d    [Axes];
  logic        [Prod3W-1:0] mag_d   [Axes];
  logic        [63:0]       p5_d    [Axes];
  logic        [FieldW-1:0] field_d [Axes];

  logic                     div_start;
  logic [Axes-1:0]          div_done;
  logic [DvdW-1:0]          div_quot [Axes];
  logic                     out_free;

  assign out_free  = !out_valid_o || !out_stall_i;
  assign pop_o     = (state_q == StIdle) && head_i.valid;
  assign div_start = (state_q == StPrep);
  assign count_inc = (count_q < target_i) ? count_q + 16'd1 : count_q;

  always_comb begin
    total_d = '0;
    for (int a = 0; a < Axes; a++) begin
      min_d[a]   = ($signed(head_i.item.raw[a]) < min_q[a]) ?
                   $signed(head_i.item.raw[a]) : min_q[a];
      max_d[a]   = ($signed(head_i.item.raw[a]) > max_q[a]) ?
                   $signed(head_i.item.raw[a]) : max_q[a];
      range_d[a] = RawW'(max_q[a] - min_q[a]);
      total_d    = total_d + TotalW'(range_d[a]);
      dvs_d[a]   = DvsW'(range_d[a]) + DvsW'({range_d[a], 1'b0});
      diff_d[a]  = $signed({raw_q[a], 1'b0}) - $signed({mid_q[a][MidW-1], mid_q[a]});
      prod_d[a]  = diff_d[a] * $signed({1'b0, scale_q[a]});
      p3_d[a]    = $signed({prod_q[a][ProdW-1], prod_q[a]}) + $signed({prod_q[a], 1'b0});
      mag_d[a]   = p3_d[a][Prod3W-1] ? Prod3W'(-p3_d[a]) : Prod3W'(p3_d[a]);
      p5_d[a]    = {32'd0, sh_q[a]} * {32'd0, mic_pkg::RecipFive};
      field_d[a] = neg_q[a] ? FieldW'(-{2'b00, quot_q[a]}) : {2'b00, quot_q[a]};
    end
  end

  for (genvar g = 0; g < Axes; g++) begin : gen_div
    mic_div #(
      .DvdW(DvdW),
      .DvsW(DvsW)
    ) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (div_start),
      .dividend_i({total_d, {mic_pkg::FracW{1'b0}}}),
      .divisor_i (dvs_d[g]),
      .done_o    (div_done[g]),
      .quot_o    (div_quot[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      done_q       <= 1'b0;
      out_valid_o  <= 1'b0;
      calibrated_o <= 1'b0;
      for (int a = 0; a < Axes; a++) begin
        min_q[a]   <= $signed({1'b0, {(RawW-1){1'b1}}});
        max_q[a]   <= $signed({1'b1, {(RawW-1){1'b0}}});
        mid_q[a]   <= '0;
        scale_q[a] <= mic_pkg::ScaleOne;
        zero_q[a]  <= 1'b0;
      end
    end else begin
      // Drop the output item once taken, unless a new one replaces it
      if (out_valid_o && !out_stall_i && (state_q != StOut)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (head_i.valid) begin
            if (head_i.cal) begin
              for (int a = 0; a < Axes; a++) begin
                min_q[a] <= min_d[a];
                max_q[a] <= max_d[a];
              end
              count_q <= count_inc;
              state_q <= (count_inc >= target_i) ? StPrep : StMul;
            end else begin
              state_q <= StMul;
            end
          end
        end
        StPrep: begin
          for (int a = 0; a < Axes; a++) begin
            mid_q[a]  <= $signed({min_q[a][RawW-1], min_q[a]}) +
                         $signed({max_q[a][RawW-1], max_q[a]});
            zero_q[a] <= (range_d[a] == '0);
          end
          state_q <= StDiv;
        end
        StDiv: begin
          if (&div_done) begin
            for (int a = 0; a < Axes; a++) begin
              if (zero_q[a]) begin
                scale_q[a] <= mic_pkg::ScaleOne;
              end else if (div_quot[a][DvdW-1:ScaleW] != '0) begin
                scale_q[a] <= mic_pkg::ScaleMax;
              end else begin
                scale_q[a] <= div_quot[a][ScaleW-1:0];
              end
            end
            done_q  <= 1'b1;
            state_q <= StMul;
          end
        end
        StMul: begin
          state_q <= StScale;
        end
        StScale: begin
          state_q <= StRecip;
        end
        StRecip: begin
          state_q <= StOut;
        end
        StOut: begin
          if (out_free) begin
            out_valid_o  <= 1'b1;
            calibrated_o <= done_q;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Datapath registers: no reset needed
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < Axes; a++) begin
      if (pop_o) begin
        raw_q[a] <= $signed(head_i.item.raw[a]);
      end
      if (state_q == StMul) begin
        prod_q[a] <= prod_d[a];
      end
      if (state_q == StScale) begin
        neg_q[a] <= p3_d[a][Prod3W-1];
        sh_q[a]  <= mag_d[a][Prod3W-2:11];
      end
      if (state_q == StRecip) begin
        quot_q[a] <= p5_d[a][63:34];
      end
    end
    if ((state_q == StOut) && out_free) begin
      field_x_o <= field_d[0];
      field_y_o <= field_d[1];
      field_z_o <= field_d[2];
    end
  end

endmodule

`default_nettype wire
